// ===== sv/pli_pkg.sv =====
// Shared constants and types for the inverse piecewise linear lookup.
package pli_pkg;

  localparam int FIELD_W = 32;  // external value fields, signed Q16.16
  localparam int IDX_W   = 6;   // point index field
  localparam int CNT_W   = 7;   // point count register
  localparam int KIND_W  = 2;   // result kind field

  // Request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_INTERP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LAST   = 2'd2;

  // Point count reset value and lower limit
  localparam logic [CNT_W-1:0] CNT_RESET = 7'd2;
  localparam logic [CNT_W-1:0] CNT_MIN   = 7'd2;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic [IDX_W-1:0]          index_t;
  typedef logic [KIND_W-1:0]         kind_t;

endpackage

// ===== sv/pli_if.sv =====
// Request and result channel interfaces (valid/ready handshake).
interface pli_req_if;
  import pli_pkg::*;

  logic   valid;
  logic   ready;
  logic   req_type;
  index_t point_index;
  field_t point_x;
  field_t point_y;
  field_t query_value;

  modport source (
    output valid, req_type, point_index, point_x, point_y, query_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, point_index, point_x, point_y, query_value,
    output ready
  );
endinterface

interface pli_rsp_if;
  import pli_pkg::*;

  logic   valid;
  logic   ready;
  field_t result_x;
  kind_t  result_kind;

  modport source (
    output valid, result_x, result_kind,
    input  ready
  );
  modport sink (
    input  valid, result_x, result_kind,
    output ready
  );
endinterface

// ===== sv/pli_table.sv =====
// Support point storage: abscissa and ordinate memories, one write and one read port.
module pli_table #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wx_i,
  input  logic [WIDTH-1:0]         wy_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rx_o,
  output logic [WIDTH-1:0]         ry_o
);

  logic [WIDTH-1:0] xmem [DEPTH];
  logic [WIDTH-1:0] ymem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      xmem[waddr_i] <= wx_i;
      ymem[waddr_i] <= wy_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rx_o <= xmem[raddr_i];
    ry_o <= ymem[raddr_i];
  end

endmodule

// ===== sv/pli_alu.sv =====
// Shared add/subtract unit with carry out.
module pli_alu #(
  parameter int WIDTH = 33
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             sub_i,
  output logic [WIDTH-1:0] res_o,
  output logic             co_o
);

  logic [WIDTH:0] sum;

  // sub: a + ~b + 1; carry out set means a >= b (unsigned)
  assign sum   = {1'b0, a_i} + {1'b0, b_i ^ {WIDTH{sub_i}}} + (WIDTH+1)'(sub_i);
  assign res_o = sum[WIDTH-1:0];
  assign co_o  = sum[WIDTH];

endmodule

// ===== sv/piecewise_linear_inverse_lookup.sv =====
// Sequence: a load writes the table when accepted; a query reads the first and last points, then
// checks direction and range (a clamped result goes to emit), scans for the interval (a flat one
// goes to emit), forms the differences, negating any negative one, multiplies, divides and adds.
// Throughput: one query at a time; the table scan reads one entry per cycle from the single
// read port, multiply and divide run one bit per cycle; a full output register holds emit.
// Reset: async active low; clears the sequencer, output valid and sets point_count to 2.
module piecewise_linear_inverse_lookup #(
  parameter int MAX_POINTS  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pli_pkg::CNT_W-1:0] cfg_wdata_i,
  pli_req_if.sink                   req,
  pli_rsp_if.source                 rsp
);
  import pli_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(VALUE_WIDTH);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;   // ready for a request
  localparam logic [3:0] S_RD0  = 4'd1;   // read first point
  localparam logic [3:0] S_RDL  = 4'd2;   // read last point, capture first
  localparam logic [3:0] S_CLMP = 4'd3;   // direction and range check
  localparam logic [3:0] S_SCAN = 4'd4;   // interval search, one entry per cycle
  localparam logic [3:0] S_SUB  = 4'd5;   // difference through the adder
  localparam logic [3:0] S_NEG  = 4'd6;   // negate a negative difference
  localparam logic [3:0] S_MUL  = 4'd7;   // shift-add multiply dx * dq
  localparam logic [3:0] S_DIV  = 4'd8;   // restoring divide by dy
  localparam logic [3:0] S_FIN  = 4'd9;   // xi +/- quotient
  localparam logic [3:0] S_EMIT = 4'd10;  // hand result to output register

  // Difference selects
  localparam logic [1:0] SEL_DX = 2'd0;   // xi1 - xi
  localparam logic [1:0] SEL_DQ = 2'd1;   // q - yi
  localparam logic [1:0] SEL_DY = 2'd2;   // yi1 - yi

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] pcnt_q;
  logic [AW-1:0]    last_idx;

  // query context
  logic [VW-1:0] q_q;
  logic [VW-1:0] px_q, py_q;          // previously read point
  logic          ninc_q;
  logic [AW-1:0] ptr_q;
  logic [VW-1:0] xi_q, yi_q, xi1_q, yi1_q;

  // arithmetic registers
  logic [1:0]    sel_q;
  logic          sign_q;
  logic [VW:0]   t_q;
  logic [VW-1:0] mc_q;                // multiplicand dx
  logic [VW-1:0] ph_q, pl_q;          // product high/low; remainder and quotient
  logic [VW-1:0] dvs_q;               // divisor dy
  logic [CW-1:0] step_q;

  logic [FIELD_W-1:0] res_q;
  kind_t              kind_q;

  logic               out_vld_q;
  logic [FIELD_W-1:0] out_x_q;
  kind_t              out_kind_q;

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [VW-1:0] rd_x, rd_y;

  // adder
  logic [VW:0] alu_a, alu_b, alu_res;
  logic        alu_sub, alu_co;

  logic          req_acc, slot_free, idx_ok;
  logic          ninc_now, clamp_first, clamp_last, hit, flat, neg, diff_done, step_last;
  logic [AW-1:0] k0;
  logic [VW-1:0] xi_sel, yi_sel, xi1_sel, yi1_sel;

  // ---------------------------------------------------------------------------
  // Configuration: point count, limited to [2, MAX_POINTS] on use
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= CNT_RESET;
    end else if (cfg_we_i) begin
      pcnt_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (pcnt_q < CNT_MIN) begin
      last_idx = AW'(1);
    end else if (32'(pcnt_q) >= 32'(MAX_POINTS)) begin
      last_idx = AW'(MAX_POINTS - 1);
    end else begin
      last_idx = AW'(pcnt_q - 7'd1);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and table write
  // ---------------------------------------------------------------------------
  assign req.ready = (state_q == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign slot_free = !out_vld_q || rsp.ready;

  // loads beyond the table depth are dropped
  assign idx_ok    = 32'(req.point_index) < 32'(MAX_POINTS);
  assign mem_we    = req_acc && (req.req_type == REQ_LOAD) && idx_ok;
  assign mem_waddr = AW'(req.point_index);

  pli_table #(
    .DEPTH (MAX_POINTS),
    .WIDTH (VW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wx_i    (VW'(req.point_x)),
    .wy_i    (VW'(req.point_y)),
    .raddr_i (mem_raddr),
    .rx_o    (rd_x),
    .ry_o    (rd_y)
  );

  // ---------------------------------------------------------------------------
  // Decisions on the read data
  // ---------------------------------------------------------------------------
  // In S_CLMP py_q holds the first y and rd_y the last y.
  // Equal end ordinates count as decreasing.
  assign ninc_now    = $signed(py_q) < $signed(rd_y);
  assign clamp_first = ninc_now ? !($signed(py_q) < $signed(q_q))
                                : !($signed(q_q) < $signed(py_q));
  assign clamp_last  = ninc_now ? !($signed(q_q) < $signed(rd_y))
                                : !($signed(rd_y) < $signed(q_q));
  // first scan entry: 1 going up, n-2 going down
  assign k0 = ninc_now ? AW'(1) : last_idx - AW'(1);

  // scan hit: entry y not below the query; both directions stop at first hit
  assign hit     = !($signed(rd_y) < $signed(q_q));
  assign xi_sel  = ninc_q ? px_q : rd_x;
  assign yi_sel  = ninc_q ? py_q : rd_y;
  assign xi1_sel = ninc_q ? rd_x : px_q;
  assign yi1_sel = ninc_q ? rd_y : py_q;
  assign flat    = (yi_sel == yi1_sel);

  assign neg       = alu_res[VW];
  assign diff_done = (state_q == S_NEG) || ((state_q == S_SUB) && !neg);
  assign step_last = (step_q == CW'(VW - 1));

  always_comb begin
    unique case (state_q)
      S_RD0:   mem_raddr = '0;
      S_RDL:   mem_raddr = last_idx;
      S_CLMP:  mem_raddr = k0;
      S_SCAN:  mem_raddr = ptr_q;
      default: mem_raddr = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared adder: differences and their negation, multiply steps, divide steps, final sum
  // ---------------------------------------------------------------------------
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_SUB: begin
        alu_sub = 1'b1;
        unique case (sel_q)
          SEL_DX: begin
            alu_a = {xi1_q[VW-1], xi1_q};
            alu_b = {xi_q[VW-1], xi_q};
          end
          SEL_DQ: begin
            alu_a = {q_q[VW-1], q_q};
            alu_b = {yi_q[VW-1], yi_q};
          end
          SEL_DY: begin
            alu_a = {yi1_q[VW-1], yi1_q};
            alu_b = {yi_q[VW-1], yi_q};
          end
          default: begin
            alu_a = '0;
            alu_b = '0;
          end
        endcase
      end
      S_NEG: begin
        alu_sub = 1'b1;
        alu_b   = t_q;
      end
      S_MUL: begin
        alu_a = {1'b0, ph_q};
        alu_b = pl_q[0] ? {1'b0, mc_q} : '0;
      end
      S_DIV: begin
        alu_sub = 1'b1;
        alu_a   = {ph_q, pl_q[VW-1]};
        alu_b   = {1'b0, dvs_q};
      end
      S_FIN: begin
        alu_sub = sign_q;
        alu_a   = {xi_q[VW-1], xi_q};
        alu_b   = {1'b0, pl_q};
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  pli_alu #(
    .WIDTH (VW + 1)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .co_o  (alu_co)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req_acc && (req.req_type == REQ_QUERY)) state_d = S_RD0;
      S_RD0:  state_d = S_RDL;
      S_RDL:  state_d = S_CLMP;
      S_CLMP: state_d = (clamp_first || clamp_last) ? S_EMIT : S_SCAN;
      S_SCAN: begin
        if (hit) begin
          state_d = flat ? S_EMIT : S_SUB;
        end
      end
      S_SUB: begin
        if (neg) begin
          state_d = S_NEG;
        end else if (sel_q == SEL_DY) begin
          state_d = S_MUL;
        end
      end
      S_NEG:  state_d = (sel_q == SEL_DY) ? S_MUL : S_SUB;
      S_MUL:  if (step_last) state_d = S_DIV;
      S_DIV:  if (step_last) state_d = S_FIN;
      S_FIN:  state_d = S_EMIT;
      S_EMIT: if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) q_q <= VW'(req.query_value);
      end
      S_RDL: begin
        px_q <= rd_x;
        py_q <= rd_y;
      end
      S_CLMP: begin
        ninc_q <= ninc_now;
        ptr_q  <= ninc_now ? AW'(2) : last_idx - AW'(2);
        if (clamp_first) begin
          res_q  <= FIELD_W'($signed(px_q));
          kind_q <= KIND_FIRST;
        end else if (clamp_last) begin
          res_q  <= FIELD_W'($signed(rd_x));
          kind_q <= KIND_LAST;
        end else if (!ninc_now) begin
          // going down, the last point is the upper neighbor
          px_q <= rd_x;
          py_q <= rd_y;
        end
      end
      S_SCAN: begin
        if (hit) begin
          xi_q   <= xi_sel;
          yi_q   <= yi_sel;
          xi1_q  <= xi1_sel;
          yi1_q  <= yi1_sel;
          sign_q <= 1'b0;
          sel_q  <= SEL_DX;
          res_q  <= FIELD_W'(xi_sel);   // flat interval result
          kind_q <= KIND_INTERP;
        end else begin
          px_q  <= rd_x;
          py_q  <= rd_y;
          ptr_q <= ninc_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
        end
      end
      S_SUB: begin
        if (neg) begin
          t_q    <= alu_res;
          sign_q <= ~sign_q;
        end
      end
      S_MUL: begin
        ph_q   <= alu_res[VW:1];
        pl_q   <= {alu_res[0], pl_q[VW-1:1]};
        step_q <= step_last ? '0 : step_q + CW'(1);
      end
      S_DIV: begin
        ph_q   <= alu_co ? alu_res[VW-1:0] : {ph_q[VW-2:0], pl_q[VW-1]};
        pl_q   <= {pl_q[VW-2:0], alu_co};
        step_q <= step_last ? '0 : step_q + CW'(1);
      end
      S_FIN: begin
        res_q  <= FIELD_W'(alu_res[VW-1:0]);
        kind_q <= KIND_INTERP;
      end
      default: begin
      end
    endcase

    // a magnitude is ready: park it and move to the next difference
    if (diff_done) begin
      unique case (sel_q)
        SEL_DX:  mc_q  <= alu_res[VW-1:0];
        SEL_DQ:  pl_q  <= alu_res[VW-1:0];
        SEL_DY:  dvs_q <= alu_res[VW-1:0];
        default: mc_q  <= mc_q;
      endcase
      sel_q  <= sel_q + 2'd1;
      ph_q   <= '0;
      step_q <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((state_q == S_EMIT) && slot_free) begin
      out_vld_q <= 1'b1;
    end else if (rsp.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_EMIT) && slot_free) begin
      out_x_q    <= res_q;
      out_kind_q <= kind_q;
    end
  end

  assign rsp.valid       = out_vld_q;
  assign rsp.result_x    = out_x_q;
  assign rsp.result_kind = out_kind_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // interval choice keeps dq <= dy, so the remainder never reaches the divisor
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (ph_q < dvs_q))
    else $error("divide remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_MUL) || (state_q == S_DIV)) |-> (dvs_q != '0))
    else $error("zero divisor in multiply/divide");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready && (req.req_type == REQ_QUERY)) |=>
      ((state_q == S_RD0) && !req.ready))
    else $error("query request did not start the sequencer");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp.valid) |-> ($past(state_q) == S_EMIT))
    else $error("result valid raised outside emit");

endmodule
